// File: design/tgee_pkg.sv
// Shared types and constants for the tile grid edge extractor.
// No dependencies; every other design file imports this package.
`default_nettype none
package tgee_pkg;

	localparam int COORD_W = 15;
	localparam int TS_W    = 9;

	localparam logic [1:0] CLS_EMPTY    = 2'd0;
	localparam logic [1:0] CLS_SOLID    = 2'd1;
	localparam logic [1:0] CLS_ONE_WAY  = 2'd2;
	localparam logic [1:0] CLS_RESERVED = 2'd3;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_FETCH = 1'b1;

	localparam logic [1:0] CFG_COLS = 2'd0;
	localparam logic [1:0] CFG_ROWS = 2'd1;
	localparam logic [1:0] CFG_TILE = 2'd2;

	localparam logic [2:0] SIDE_CENTER = 3'd0;
	localparam logic [2:0] SIDE_TOP    = 3'd1;
	localparam logic [2:0] SIDE_BOTTOM = 3'd2;
	localparam logic [2:0] SIDE_LEFT   = 3'd3;
	localparam logic [2:0] SIDE_RIGHT  = 3'd4;

	typedef struct packed {
		logic               one_way;
		logic [COORD_W-1:0] y2;
		logic [COORD_W-1:0] x2;
		logic [COORD_W-1:0] y1;
		logic [COORD_W-1:0] x1;
	} edge_t;

	typedef struct packed {
		logic  we;
		edge_t data;
	} edge_wr_t;

endpackage
`default_nettype wire

// File: design/tile_grid_edge_extract_merge.sv
// Top level of the tile grid edge extractor: configuration, load and fetch control,
// output register. Depends on tgee_pkg, tgee_scan and tgee_merge.
//
// channel   direction  fields
// s_*       in         tuser[0] cmd; tdata[1:0] tile_class
// m_*       out        tdata x1,y1,x2,y2,one_way; tuser[0] seg_valid; tlast seg_last
// cfg_*     in         cfg_index 0 cols, 1 rows, 2 tile pixels; cfg_data value
//
// The load that completes the map starts the scan, up to five tile-store reads per
// tile, then the merge pass, which compares each unabsorbed edge with every later edge.
// A fetch goes through the segment store read port.
// Reset clears all counters; the stores are not cleared. s_tready is low during
// scan, merge and fetch; a fetch waits while the output register is still full.
`default_nettype none
module tile_grid_edge_extract_merge #(
	parameter int MAX_COLS = 64,
	parameter int MAX_ROWS = 64
) (
	input  wire  logic        clk,
	input  wire  logic        arst_n,
	input  wire  logic        s_tvalid,
	output logic              s_tready,
	input  wire  logic [7:0]  s_tdata,   // [1:0] tile_class
	input  wire  logic [0:0]  s_tuser,   // [0] cmd
	output logic              m_tvalid,
	input  wire  logic        m_tready,
	output logic [63:0]       m_tdata,   // [14:0] x1, [29:15] y1, [44:30] x2, [59:45] y2, [60] one_way
	output logic [0:0]        m_tuser,   // [0] seg_valid
	output logic              m_tlast,
	input  wire  logic        cfg_valid,
	output logic              cfg_ready,
	input  wire  logic [1:0]  cfg_index,
	input  wire  logic [8:0]  cfg_data
);
	import tgee_pkg::*;

	localparam int CELLS = MAX_COLS * MAX_ROWS;
	localparam int TW    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int EW    = TW + 2;
	localparam int ECW   = $clog2(4 * CELLS + 1);
	localparam int TLW   = $clog2(CELLS + 1);
	localparam int CLW   = $clog2(MAX_COLS + 1);
	localparam int RLW   = $clog2(MAX_ROWS + 1);

	localparam logic [1:0] T_IDLE  = 2'd0;
	localparam logic [1:0] T_SCAN  = 2'd1;
	localparam logic [1:0] T_MERGE = 2'd2;
	localparam logic [1:0] T_FETCH = 2'd3;

	logic [6:0]      cols_cfg_q;
	logic [6:0]      rows_cfg_q;
	logic [8:0]      ts_cfg_q;
	logic [CLW-1:0]  cols_c;
	logic [RLW-1:0]  rows_c;
	logic [TS_W-1:0] ts_c;
	logic [TLW-1:0]  total;
	logic [TLW-1:0]  loaded_q;
	logic [TLW-1:0]  load_base;
	logic [TLW-1:0]  load_next;
	logic [ECW-1:0]  fp_q;
	logic [1:0]      state_q;
	logic            accept;
	logic            load_acc;
	logic            restart;
	logic            complete;
	logic [1:0]      cls_in;
	edge_wr_t        edge_wr;
	logic            scan_done;
	logic            merge_done;
	edge_t           seg_rd;
	logic [ECW-1:0]  seg_total;
	logic            hit;
	logic            out_free;
	logic            out_v_q;
	edge_t           out_seg_q;
	logic            out_ok_q;
	logic            out_last_q;

	always_comb begin
		if (cols_cfg_q == '0) begin
			cols_c = CLW'(1);
		end else if (int'(cols_cfg_q) > MAX_COLS) begin
			cols_c = CLW'(MAX_COLS);
		end else begin
			cols_c = CLW'(cols_cfg_q);
		end
		if (rows_cfg_q == '0) begin
			rows_c = RLW'(1);
		end else if (int'(rows_cfg_q) > MAX_ROWS) begin
			rows_c = RLW'(MAX_ROWS);
		end else begin
			rows_c = RLW'(rows_cfg_q);
		end
		if (ts_cfg_q == '0) begin
			ts_c = TS_W'(1);
		end else if (ts_cfg_q > 9'd256) begin
			ts_c = TS_W'(256);
		end else begin
			ts_c = ts_cfg_q;
		end
	end

	assign total     = TLW'(cols_c) * TLW'(rows_c);
	assign accept    = s_tvalid && s_tready;
	assign load_acc  = accept && (s_tuser[0] == CMD_LOAD);
	assign restart   = (loaded_q >= total);
	assign load_base = restart ? '0 : loaded_q;
	assign load_next = load_base + TLW'(1);
	assign complete  = load_acc && (load_next == total);
	assign cls_in    = (s_tdata[1:0] == CLS_RESERVED) ? CLS_SOLID : s_tdata[1:0];
	assign s_tready  = (state_q == T_IDLE);
	assign cfg_ready = 1'b1;
	assign hit       = (fp_q < seg_total);
	assign out_free  = !out_v_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_cfg_q <= 7'd64;
			rows_cfg_q <= 7'd64;
			ts_cfg_q   <= 9'd32;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_COLS: cols_cfg_q <= cfg_data[6:0];
				CFG_ROWS: rows_cfg_q <= cfg_data[6:0];
				CFG_TILE: ts_cfg_q   <= cfg_data;
				default:  ;
			endcase
		end
	end

	tgee_scan #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.tile_we   (load_acc),
		.tile_addr (load_base[TW-1:0]),
		.tile_cls  (cls_in),
		.start     (complete),
		.cols      (cols_c),
		.rows      (rows_c),
		.ts        (ts_c),
		.edge_wr   (edge_wr),
		.done      (scan_done)
	);

	tgee_merge #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (load_acc && (restart || complete)),
		.edge_wr   (edge_wr),
		.start     ((state_q == T_SCAN) && scan_done),
		.seg_addr  (fp_q[EW-1:0]),
		.seg_rd    (seg_rd),
		.seg_total (seg_total),
		.done      (merge_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= T_IDLE;
			loaded_q   <= '0;
			fp_q       <= '0;
			out_v_q    <= 1'b0;
		end else begin
			if ((state_q == T_FETCH) && out_free) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				T_IDLE: begin
					if (load_acc) begin
						loaded_q <= load_next;
						if (restart || complete) begin
							fp_q <= '0;
						end
						if (complete) begin
							state_q <= T_SCAN;
						end
					end else if (accept) begin
						state_q <= T_FETCH;
					end
				end
				T_SCAN: begin
					if (scan_done) begin
						state_q <= T_MERGE;
					end
				end
				T_MERGE: begin
					if (merge_done) begin
						state_q <= T_IDLE;
					end
				end
				T_FETCH: begin
					if (out_free) begin
						state_q <= T_IDLE;
						if (hit) begin
							fp_q <= fp_q + ECW'(1);
						end
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == T_FETCH) && out_free) begin
			out_seg_q  <= hit ? seg_rd : '0;
			out_ok_q   <= hit;
			out_last_q <= hit && (fp_q + ECW'(1) == seg_total);
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {3'b000, out_seg_q};
	assign m_tuser  = out_ok_q;
	assign m_tlast  = out_last_q;

endmodule
`default_nettype wire

// File: design/tgee_scan.sv
// Tile store and boundary scan: walks the loaded map one neighbor read at a time
// and emits exposed tile sides. Depends on tgee_pkg.
`default_nettype none
module tgee_scan #(
	parameter int MAX_COLS = 64,
	parameter int MAX_ROWS = 64
) (
	input  wire  logic                                        clk,
	input  wire  logic                                        arst_n,
	input  wire  logic                                        tile_we,
	input  wire  logic [((MAX_COLS*MAX_ROWS>1) ? $clog2(MAX_COLS*MAX_ROWS) : 1)-1:0] tile_addr,
	input  wire  logic [1:0]                                  tile_cls,
	input  wire  logic                                        start,
	input  wire  logic [$clog2(MAX_COLS+1)-1:0]               cols,
	input  wire  logic [$clog2(MAX_ROWS+1)-1:0]               rows,
	input  wire  logic [tgee_pkg::TS_W-1:0]                   ts,
	output tgee_pkg::edge_wr_t                                edge_wr,
	output logic                                              done
);
	import tgee_pkg::*;

	localparam int CELLS = MAX_COLS * MAX_ROWS;
	localparam int TW    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int CLW   = $clog2(MAX_COLS + 1);
	localparam int RLW   = $clog2(MAX_ROWS + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RD   = 2'd1;
	localparam logic [1:0] S_EV   = 2'd2;

	logic [1:0]         tile_mem [CELLS];
	logic [1:0]         rd_q;
	logic [TW-1:0]      rd_addr;
	logic [1:0]         state_q;
	logic [2:0]         side_q;
	logic [CLW-1:0]     c_q;
	logic [CLW-1:0]     cols_q;
	logic [RLW-1:0]     r_q;
	logic [RLW-1:0]     rows_q;
	logic [TS_W-1:0]    ts_q;
	logic [TW-1:0]      idx_q;
	logic [COORD_W-1:0] xa_q;
	logic [COORD_W-1:0] ya_q;
	logic [COORD_W-1:0] xb;
	logic [COORD_W-1:0] yb;
	logic               ow_q;
	logic               border;
	logic               exposed;
	logic               tile_end;
	logic               done_q;

	always_ff @(posedge clk) begin
		if (tile_we) begin
			tile_mem[tile_addr] <= tile_cls;
		end
		rd_q <= tile_mem[rd_addr];
	end

	always_comb begin
		unique case (side_q)
			SIDE_TOP:    rd_addr = idx_q - TW'(cols_q);
			SIDE_BOTTOM: rd_addr = idx_q + TW'(cols_q);
			SIDE_LEFT:   rd_addr = idx_q - TW'(1);
			SIDE_RIGHT:  rd_addr = idx_q + TW'(1);
			default:     rd_addr = idx_q;
		endcase
	end

	assign xb = xa_q + COORD_W'(ts_q);
	assign yb = ya_q + COORD_W'(ts_q);

	always_comb begin
		unique case (side_q)
			SIDE_TOP:    border = (r_q == '0);
			SIDE_BOTTOM: border = (r_q == rows_q - RLW'(1));
			SIDE_LEFT:   border = (c_q == '0);
			SIDE_RIGHT:  border = (c_q == cols_q - CLW'(1));
			default:     border = 1'b0;
		endcase
	end

	assign exposed = border || (rd_q == CLS_EMPTY);

	always_comb begin
		edge_wr.we = (state_q == S_EV) && (side_q != SIDE_CENTER) && exposed;
		edge_wr.data.one_way = ow_q;
		unique case (side_q)
			SIDE_TOP: begin
				edge_wr.data.x1 = xa_q; edge_wr.data.y1 = ya_q;
				edge_wr.data.x2 = xb;   edge_wr.data.y2 = ya_q;
			end
			SIDE_BOTTOM: begin
				edge_wr.data.x1 = xa_q; edge_wr.data.y1 = yb;
				edge_wr.data.x2 = xb;   edge_wr.data.y2 = yb;
			end
			SIDE_LEFT: begin
				edge_wr.data.x1 = xa_q; edge_wr.data.y1 = ya_q;
				edge_wr.data.x2 = xa_q; edge_wr.data.y2 = yb;
			end
			default: begin
				edge_wr.data.x1 = xb;   edge_wr.data.y1 = ya_q;
				edge_wr.data.x2 = xb;   edge_wr.data.y2 = yb;
			end
		endcase
	end

	always_comb begin
		tile_end = 1'b0;
		if (state_q == S_EV) begin
			if (side_q == SIDE_CENTER) begin
				tile_end = (rd_q == CLS_EMPTY);
			end else if (side_q == SIDE_TOP) begin
				tile_end = ow_q;
			end else if (side_q == SIDE_RIGHT) begin
				tile_end = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			side_q  <= SIDE_CENTER;
			done_q  <= 1'b0;
			c_q     <= '0;
			r_q     <= '0;
			idx_q   <= '0;
			xa_q    <= '0;
			ya_q    <= '0;
			ow_q    <= 1'b0;
			cols_q  <= '0;
			rows_q  <= '0;
			ts_q    <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_RD;
						side_q  <= SIDE_CENTER;
						c_q     <= '0;
						r_q     <= '0;
						idx_q   <= '0;
						xa_q    <= '0;
						ya_q    <= '0;
						cols_q  <= cols;
						rows_q  <= rows;
						ts_q    <= ts;
					end
				end
				S_RD: begin
					state_q <= S_EV;
				end
				S_EV: begin
					if (side_q == SIDE_CENTER) begin
						ow_q <= (rd_q == CLS_ONE_WAY);
					end
					if (tile_end) begin
						side_q <= SIDE_CENTER;
						idx_q  <= idx_q + TW'(1);
						if (c_q == cols_q - CLW'(1)) begin
							c_q  <= '0;
							xa_q <= '0;
							ya_q <= yb;
							r_q  <= r_q + RLW'(1);
							if (r_q == rows_q - RLW'(1)) begin
								state_q <= S_IDLE;
								done_q  <= 1'b1;
							end else begin
								state_q <= S_RD;
							end
						end else begin
							c_q     <= c_q + CLW'(1);
							xa_q    <= xb;
							state_q <= S_RD;
						end
					end else begin
						side_q  <= side_q + 3'd1;
						state_q <= S_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done = done_q;

endmodule
`default_nettype wire

// File: design/tgee_merge.sv
// Edge list, absorbed flags and segment store, with the greedy merge sequencer.
// Depends on tgee_pkg.
`default_nettype none
module tgee_merge #(
	parameter int MAX_COLS = 64,
	parameter int MAX_ROWS = 64
) (
	input  wire  logic                                                clk,
	input  wire  logic                                                arst_n,
	input  wire  logic                                                clear,
	input  wire  tgee_pkg::edge_wr_t                                  edge_wr,
	input  wire  logic                                                start,
	input  wire  logic [((MAX_COLS*MAX_ROWS>1) ? $clog2(MAX_COLS*MAX_ROWS) : 1)+1:0] seg_addr,
	output tgee_pkg::edge_t                                           seg_rd,
	output logic [$clog2(4*MAX_COLS*MAX_ROWS+1)-1:0]                  seg_total,
	output logic                                                      done
);
	import tgee_pkg::*;

	localparam int CELLS = MAX_COLS * MAX_ROWS;
	localparam int EDGES = 4 * CELLS;
	localparam int EW    = ((CELLS > 1) ? $clog2(CELLS) : 1) + 2;
	localparam int ECW   = $clog2(EDGES + 1);

	localparam logic [2:0] M_IDLE = 3'd0;
	localparam logic [2:0] M_I_RD = 3'd1;
	localparam logic [2:0] M_I_EV = 3'd2;
	localparam logic [2:0] M_J_RD = 3'd3;
	localparam logic [2:0] M_J_EV = 3'd4;

	edge_t           edge_mem  [EDGES];
	logic            taken_mem [EDGES];
	edge_t           seg_mem   [EDGES];
	edge_t           edge_rd_q;
	logic            taken_rd_q;
	edge_t           seg_rd_q;
	edge_t           cur_q;
	logic            vert_q;
	logic [2:0]      state_q;
	logic [ECW-1:0]  edge_total_q;
	logic [ECW-1:0]  seg_total_q;
	logic [ECW-1:0]  i_q;
	logic [ECW-1:0]  j_q;
	logic [EW-1:0]   rd_addr;
	logic            absorb;
	logic            seg_we;
	logic            done_q;

	assign rd_addr = (state_q == M_I_RD) ? i_q[EW-1:0] : j_q[EW-1:0];

	assign absorb = (state_q == M_J_EV) && !taken_rd_q
		&& ((edge_rd_q.x1 == edge_rd_q.x2) == vert_q)
		&& (edge_rd_q.x1 == cur_q.x2) && (edge_rd_q.y1 == cur_q.y2);

	assign seg_we = (state_q == M_J_RD) && (j_q == edge_total_q);

	always_ff @(posedge clk) begin
		if (edge_wr.we) begin
			edge_mem[edge_total_q[EW-1:0]]  <= edge_wr.data;
			taken_mem[edge_total_q[EW-1:0]] <= 1'b0;
		end else if (absorb) begin
			taken_mem[j_q[EW-1:0]] <= 1'b1;
		end
		if (seg_we) begin
			seg_mem[seg_total_q[EW-1:0]] <= cur_q;
		end
		edge_rd_q  <= edge_mem[rd_addr];
		taken_rd_q <= taken_mem[rd_addr];
		seg_rd_q   <= seg_mem[seg_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= M_IDLE;
			edge_total_q <= '0;
			seg_total_q  <= '0;
			i_q          <= '0;
			j_q          <= '0;
			done_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (clear) begin
				edge_total_q <= '0;
				seg_total_q  <= '0;
			end else if (edge_wr.we) begin
				edge_total_q <= edge_total_q + ECW'(1);
			end
			unique case (state_q)
				M_IDLE: begin
					if (start) begin
						i_q     <= '0;
						state_q <= M_I_RD;
					end
				end
				M_I_RD: begin
					if (i_q == edge_total_q) begin
						state_q <= M_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= M_I_EV;
					end
				end
				M_I_EV: begin
					if (taken_rd_q) begin
						i_q     <= i_q + ECW'(1);
						state_q <= M_I_RD;
					end else begin
						j_q     <= i_q + ECW'(1);
						state_q <= M_J_RD;
					end
				end
				M_J_RD: begin
					if (seg_we) begin
						seg_total_q <= seg_total_q + ECW'(1);
						i_q         <= i_q + ECW'(1);
						state_q     <= M_I_RD;
					end else begin
						state_q <= M_J_EV;
					end
				end
				M_J_EV: begin
					j_q     <= j_q + ECW'(1);
					state_q <= M_J_RD;
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == M_I_EV) begin
			cur_q  <= edge_rd_q;
			vert_q <= (edge_rd_q.x1 == edge_rd_q.x2);
		end else if (absorb) begin
			cur_q.x2 <= edge_rd_q.x2;
			cur_q.y2 <= edge_rd_q.y2;
		end
	end

	assign seg_rd    = seg_rd_q;
	assign seg_total = seg_total_q;
	assign done      = done_q;

endmodule
`default_nettype wire
